// ----- sv/p422c_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// p422c_pkg: shared types and constants
// Field widths, register indexes and layout codes for the packed 4:2:2 to
// 4:2:0 converter with vertical chroma averaging.
// ----------------------------------------------------------------------------
package p422c_pkg;

    // Configuration register widths and index codes
    localparam int CFG_DATA_W = 12;
    localparam int CFG_DIM_W  = 12;

    typedef enum logic [1:0] {
        CFG_WIDTH_PAIRS = 2'd0,
        CFG_ROW_PAIRS   = 2'd1,
        CFG_BYTE_ORDER  = 2'd2,
        CFG_PLANAR_OUT  = 2'd3
    } cfg_index_t;

    localparam logic [CFG_DIM_W-1:0] WIDTH_PAIRS_RESET = 12'd320;
    localparam logic [CFG_DIM_W-1:0] ROW_PAIRS_RESET   = 12'd240;

    // Input byte order codes
    localparam logic ORDER_YUYV = 1'b0;
    localparam logic ORDER_UYVY = 1'b1;

    // Chroma layout codes
    localparam logic LAYOUT_NV12 = 1'b0;
    localparam logic LAYOUT_I420 = 1'b1;

    // Stream payload widths
    localparam int S_TDATA_W    = 32;
    localparam int LUMA_ADDR_W  = 24;
    localparam int CHROMA_ADDR_W = 25;
    localparam int SAMPLE_W     = 8;
    localparam int M_TDATA_USED = LUMA_ADDR_W + 2 * SAMPLE_W + 2 * CHROMA_ADDR_W
                                  + 2 * SAMPLE_W;
    localparam int M_TDATA_W    = ((M_TDATA_USED + 7) / 8) * 8;

    // One line store entry: U in the low byte, V in the high byte
    typedef struct packed {
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] u;
    } chroma_pair_t;

endpackage : p422c_pkg
`default_nettype wire

// ----- sv/p422c_line_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// p422c_line_store: single-port chroma line memory
// Holds the U and V of each macropixel of an even row until the odd row
// below reads them back. Read data is registered.
// ----------------------------------------------------------------------------
module p422c_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       addr,
    input  wire p422c_pkg::chroma_pair_t wdata,
    output p422c_pkg::chroma_pair_t      rdata
);
    import p422c_pkg::*;

    chroma_pair_t mem [DEPTH];
    chroma_pair_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule : p422c_line_store
`default_nettype wire

// ----- sv/packed422_to_420_chroma_average_top.sv -----
`default_nettype none
// Each result beat is registered in stage 1, then stage 2, then the output register.
// Throughput: one macropixel per cycle; the three-stage pipeline (line store
// read, chroma offset multiply, address sum) advances whenever the output
// register is empty or being taken.
// Reset: synchronous, active low; clears the position counters and the pipeline
// valids and returns the configuration registers to their defaults. The line
// store is not cleared.
// ----------------------------------------------------------------------------
// packed422_to_420_chroma_average_top: 4:2:2 macropixel to 4:2:0 converter
// Emits both luma bytes with their frame offset and, on odd rows, the
// vertical mean of U and V with NV12 or I420 chroma offsets.
// ----------------------------------------------------------------------------
module packed422_to_420_chroma_average_top #(
    parameter int MAX_PAIRS_PER_ROW = 2048,
    parameter int MAX_ROW_PAIRS     = 2048
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire p422c_pkg::cfg_index_t               cfg_index,
    input  wire logic [p422c_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [p422c_pkg::S_TDATA_W-1:0]     s_tdata,  // packed_word[31:0]
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata from bit 0 up: luma_addr[23:0], luma_first[31:24],
    // luma_second[39:32], u_addr[64:40], v_addr[89:65], u_value[97:90],
    // v_value[105:98], zero padding[111:106]
    output logic [p422c_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tuser,  // chroma_valid
    output logic                                     m_tlast   // frame_last
);
    import p422c_pkg::*;

    localparam int COL_W = $clog2(MAX_PAIRS_PER_ROW);
    localparam int WP_W  = $clog2(MAX_PAIRS_PER_ROW + 1);
    localparam int RP_W  = $clog2(MAX_ROW_PAIRS + 1);
    localparam int ROW_W = $clog2(2 * MAX_ROW_PAIRS);
    localparam int PW    = WP_W + RP_W;
    localparam int SUM_W = (PW + 3 > CHROMA_ADDR_W) ? PW + 3 : CHROMA_ADDR_W;
    localparam int PAD_W = M_TDATA_W - M_TDATA_USED;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DIM_W-1:0] width_pairs_reg;
    logic [CFG_DIM_W-1:0] row_pairs_reg;
    logic                 byte_order_reg;
    logic                 planar_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_pairs_reg <= WIDTH_PAIRS_RESET;
            row_pairs_reg   <= ROW_PAIRS_RESET;
            byte_order_reg  <= ORDER_YUYV;
            planar_out_reg  <= LAYOUT_NV12;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WIDTH_PAIRS: width_pairs_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_ROW_PAIRS:   row_pairs_reg   <= cfg_data[CFG_DIM_W-1:0];
                CFG_BYTE_ORDER:  byte_order_reg  <= cfg_data[0];
                CFG_PLANAR_OUT:  planar_out_reg  <= cfg_data[0];
            endcase
        end
    end

    // Dimensions clamped to 1..maximum
    logic [WP_W-1:0] wp;
    logic [RP_W-1:0] rp;

    always_comb begin
        if (width_pairs_reg == '0) begin
            wp = WP_W'(1);
        end else if (32'(width_pairs_reg) > 32'(MAX_PAIRS_PER_ROW)) begin
            wp = WP_W'(MAX_PAIRS_PER_ROW);
        end else begin
            wp = WP_W'(width_pairs_reg);
        end
        if (row_pairs_reg == '0) begin
            rp = RP_W'(1);
        end else if (32'(row_pairs_reg) > 32'(MAX_ROW_PAIRS)) begin
            rp = RP_W'(MAX_ROW_PAIRS);
        end else begin
            rp = RP_W'(row_pairs_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the whole pipeline moves when the output can take a beat
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && aresetn;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0]       col_count_reg;
    logic [ROW_W-1:0]       row_count_reg;
    logic [LUMA_ADDR_W-1:0] luma_pos_reg;
    logic [COL_W-1:0]       col_count_next;
    logic [ROW_W-1:0]       row_count_next;
    logic [LUMA_ADDR_W-1:0] luma_pos_next;

    logic [WP_W-1:0] col_inc;
    logic [RP_W:0]   row_inc;
    logic            last_col;
    logic            last_row;

    assign col_inc  = WP_W'(col_count_reg) + WP_W'(1);
    assign row_inc  = (RP_W + 1)'(row_count_reg) + (RP_W + 1)'(1);
    assign last_col = col_inc >= wp;
    assign last_row = row_inc >= {rp, 1'b0};

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        luma_pos_next  = luma_pos_reg;
        if (accept) begin
            if (last_col) begin
                col_count_next = '0;
                if (last_row) begin
                    row_count_next = '0;
                    luma_pos_next  = '0;
                end else begin
                    row_count_next = row_inc[ROW_W-1:0];
                    luma_pos_next  = luma_pos_reg + LUMA_ADDR_W'(2);
                end
            end else begin
                col_count_next = col_inc[COL_W-1:0];
                luma_pos_next  = luma_pos_reg + LUMA_ADDR_W'(2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            luma_pos_reg  <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            luma_pos_reg  <= luma_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Byte unpacking and line store
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] in_y0;
    logic [SAMPLE_W-1:0] in_y1;
    chroma_pair_t        in_uv;
    chroma_pair_t        stored_uv;

    always_comb begin
        unique case (byte_order_reg)
            ORDER_YUYV: begin
                in_y0   = s_tdata[7:0];
                in_uv.u = s_tdata[15:8];
                in_y1   = s_tdata[23:16];
                in_uv.v = s_tdata[31:24];
            end
            ORDER_UYVY: begin
                in_uv.u = s_tdata[7:0];
                in_y0   = s_tdata[15:8];
                in_uv.v = s_tdata[23:16];
                in_y1   = s_tdata[31:24];
            end
        endcase
    end

    // Even rows write their chroma, odd rows read the entry of the row above
    p422c_line_store #(
        .DEPTH  (MAX_PAIRS_PER_ROW),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk  (aclk),
        .en    (accept),
        .we    (!row_count_reg[0]),
        .addr  (col_count_reg),
        .wdata (in_uv),
        .rdata (stored_uv)
    );

    // ------------------------------------------------------------------
    // Stage 1: captured item and pair count, a quarter of the luma plane size
    // ------------------------------------------------------------------
    logic                   s1_valid_reg;
    logic [SAMPLE_W-1:0]    s1_y0_reg;
    logic [SAMPLE_W-1:0]    s1_y1_reg;
    chroma_pair_t           s1_uv_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [ROW_W-2:0]       s1_row_half_reg;
    logic                   s1_odd_reg;
    logic [LUMA_ADDR_W-1:0] s1_luma_pos_reg;
    logic                   s1_last_reg;
    logic [WP_W-1:0]        s1_wp_reg;
    logic [PW-1:0]          s1_prod_reg;
    logic                   s1_planar_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_y0_reg       <= in_y0;
            s1_y1_reg       <= in_y1;
            s1_uv_reg       <= in_uv;
            s1_col_reg      <= col_count_reg;
            s1_row_half_reg <= row_count_reg[ROW_W-1:1];
            s1_odd_reg      <= row_count_reg[0];
            s1_luma_pos_reg <= luma_pos_reg;
            s1_last_reg     <= last_col && last_row;
            s1_wp_reg       <= wp;
            s1_prod_reg     <= PW'(wp) * PW'(rp);
            s1_planar_reg   <= planar_out_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: chroma index and vertical means
    // ------------------------------------------------------------------
    logic                   s2_valid_reg;
    logic [SAMPLE_W-1:0]    s2_y0_reg;
    logic [SAMPLE_W-1:0]    s2_y1_reg;
    logic                   s2_odd_reg;
    logic [LUMA_ADDR_W-1:0] s2_luma_pos_reg;
    logic                   s2_last_reg;
    logic [PW-1:0]          s2_prod_reg;
    logic [PW-1:0]          s2_c_reg;
    logic                   s2_planar_reg;
    logic [SAMPLE_W-1:0]    s2_u_avg_reg;
    logic [SAMPLE_W-1:0]    s2_v_avg_reg;

    logic [SAMPLE_W:0] u_sum;
    logic [SAMPLE_W:0] v_sum;

    assign u_sum = (SAMPLE_W + 1)'(stored_uv.u) + (SAMPLE_W + 1)'(s1_uv_reg.u);
    assign v_sum = (SAMPLE_W + 1)'(stored_uv.v) + (SAMPLE_W + 1)'(s1_uv_reg.v);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_y0_reg       <= s1_y0_reg;
            s2_y1_reg       <= s1_y1_reg;
            s2_odd_reg      <= s1_odd_reg;
            s2_luma_pos_reg <= s1_luma_pos_reg;
            s2_last_reg     <= s1_last_reg;
            s2_prod_reg     <= s1_prod_reg;
            s2_c_reg        <= PW'(s1_row_half_reg) * PW'(s1_wp_reg) + PW'(s1_col_reg);
            s2_planar_reg   <= s1_planar_reg;
            s2_u_avg_reg    <= u_sum[SAMPLE_W:1];
            s2_v_avg_reg    <= v_sum[SAMPLE_W:1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: chroma offsets into the output register
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] four_p;
    logic [SUM_W-1:0] p_ext;
    logic [SUM_W-1:0] c_ext;
    logic [SUM_W-1:0] u_sum_addr;
    logic [SUM_W-1:0] v_sum_addr;

    assign p_ext  = SUM_W'(s2_prod_reg);
    assign c_ext  = SUM_W'(s2_c_reg);
    assign four_p = p_ext << 2;

    // Chroma planes follow the luma plane, which is four times the pair count
    always_comb begin
        unique case (s2_planar_reg)
            LAYOUT_NV12: begin
                u_sum_addr = four_p + (c_ext << 1);
                v_sum_addr = four_p + (c_ext << 1) + SUM_W'(1);
            end
            LAYOUT_I420: begin
                u_sum_addr = four_p + c_ext;
                v_sum_addr = four_p + p_ext + c_ext;
            end
        endcase
    end

    logic [LUMA_ADDR_W-1:0]   out_luma_addr_reg;
    logic [SAMPLE_W-1:0]      out_luma_first_reg;
    logic [SAMPLE_W-1:0]      out_luma_second_reg;
    logic                     out_chroma_valid_reg;
    logic [CHROMA_ADDR_W-1:0] out_u_addr_reg;
    logic [CHROMA_ADDR_W-1:0] out_v_addr_reg;
    logic [SAMPLE_W-1:0]      out_u_value_reg;
    logic [SAMPLE_W-1:0]      out_v_value_reg;
    logic                     out_frame_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_luma_addr_reg    <= s2_luma_pos_reg;
            out_luma_first_reg   <= s2_y0_reg;
            out_luma_second_reg  <= s2_y1_reg;
            out_chroma_valid_reg <= s2_odd_reg;
            out_frame_last_reg   <= s2_last_reg;
            if (s2_odd_reg) begin
                out_u_addr_reg  <= u_sum_addr[CHROMA_ADDR_W-1:0];
                out_v_addr_reg  <= v_sum_addr[CHROMA_ADDR_W-1:0];
                out_u_value_reg <= s2_u_avg_reg;
                out_v_value_reg <= s2_v_avg_reg;
            end else begin
                out_u_addr_reg  <= '0;
                out_v_addr_reg  <= '0;
                out_u_value_reg <= '0;
                out_v_value_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_chroma_valid_reg;
    assign m_tlast  = out_frame_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_v_value_reg, out_u_value_reg,
                       out_v_addr_reg, out_u_addr_reg, out_luma_second_reg,
                       out_luma_first_reg, out_luma_addr_reg};

`ifndef SYNTHESIS
    // Luma offsets advance in whole pixel pairs, so they stay even.
    assert property (@(posedge aclk) disable iff (!aresetn)
        luma_pos_reg[0] == 1'b0)
        else $error("luma position became odd");

    // A beat that ends a row sends the column counter back to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_col) |=> (col_count_reg == '0))
        else $error("column counter did not wrap at the end of a row");

    // Results of even rows carry no chroma at all.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !out_chroma_valid_reg) |->
        (out_u_addr_reg == '0 && out_v_addr_reg == '0 &&
         out_u_value_reg == '0 && out_v_value_reg == '0))
        else $error("chroma fields set on an even row");

    // An item in the last internal stage reaches the output when the pipe moves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && adv) |=> m_tvalid_reg)
        else $error("beat lost between stage two and the output register");
`endif

endmodule : packed422_to_420_chroma_average_top
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4:2:2 to 4:2:0 chroma averaging converter
// A short table of hand-picked macropixels and register writes comes first,
// some rows carrying their result written out in full. A short stretch under
// oversized frame dimensions follows, then phases of random pixels under
// random frame settings. Both stream sides pause at random, and every result
// beat is compared field by field with its written-out result or with a
// prediction kept in step with the converter's counters.
// ----------------------------------------------------------------------------
module tb_top;
    import p422c_pkg::*;

    localparam int LINE_DEPTH     = 2048;
    localparam int RANDOM_PIXELS  = 520;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [LUMA_ADDR_W-1:0]   luma_addr;
        logic [SAMPLE_W-1:0]      luma_first;
        logic [SAMPLE_W-1:0]      luma_second;
        logic                     chroma_valid;
        logic [CHROMA_ADDR_W-1:0] u_addr;
        logic [CHROMA_ADDR_W-1:0] v_addr;
        logic [SAMPLE_W-1:0]      u_value;
        logic [SAMPLE_W-1:0]      v_value;
        logic                     frame_last;
    } pixel_result_t;

    typedef enum {ROW_PIXEL, ROW_WRITE} plan_kind_t;

    typedef struct {
        plan_kind_t          kind;
        cfg_index_t          sel;
        logic [CFG_DATA_W-1:0] val;
        logic [31:0]         word;
        bit                  typed;
        pixel_result_t       res;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    cfg_index_t cfg_index = CFG_WIDTH_PAIRS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    // Predicted converter state
    logic [CFG_DIM_W-1:0] cur_width = WIDTH_PAIRS_RESET;
    logic [CFG_DIM_W-1:0] cur_rows  = ROW_PAIRS_RESET;
    logic cur_order  = ORDER_YUYV;
    logic cur_layout = LAYOUT_NV12;
    logic [SAMPLE_W-1:0] line_u [LINE_DEPTH];
    logic [SAMPLE_W-1:0] line_v [LINE_DEPTH];
    int col_cnt = 0;
    int row_cnt = 0;
    logic [LUMA_ADDR_W-1:0] luma_pos = '0;

    pixel_result_t pending_results[$];
    plan_row_t plan[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int ready_hold = 0;
    bit calm = 1'b0;

    always #5 aclk = ~aclk;

    packed422_to_420_chroma_average_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int k;
        w = $urandom;
        // Push some bytes to the ends of their range to stress the averaging.
        if ($urandom_range(9) < 3) begin
            for (k = 0; k < 4; k++) begin
                case ($urandom_range(2))
                    0: w[8*k +: 8] = 8'h00;
                    1: w[8*k +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Works out the result beat of one macropixel and advances the counters.
    function automatic pixel_result_t convert_pixel(input logic [31:0] word);
        pixel_result_t r;
        logic [SAMPLE_W-1:0] y0, y1, u, v;
        logic [SAMPLE_W:0] u_sum, v_sum;
        int wp, rp, ysize, c;
        bit last_col, last_row;
        wp = clamp_dim(cur_width, LINE_DEPTH);
        rp = clamp_dim(cur_rows, LINE_DEPTH);
        last_col = (col_cnt + 1) >= wp;
        last_row = (row_cnt + 1) >= 2 * rp;
        if (cur_order == ORDER_YUYV) begin
            y0 = word[7:0];
            u  = word[15:8];
            y1 = word[23:16];
            v  = word[31:24];
        end else begin
            u  = word[7:0];
            y0 = word[15:8];
            v  = word[23:16];
            y1 = word[31:24];
        end
        r = '0;
        r.luma_addr   = luma_pos;
        r.luma_first  = y0;
        r.luma_second = y1;
        r.frame_last  = last_col && last_row;
        if (row_cnt % 2 == 0) begin
            line_u[col_cnt] = u;
            line_v[col_cnt] = v;
        end else begin
            ysize = 4 * wp * rp;
            c = (row_cnt / 2) * wp + col_cnt;
            u_sum = line_u[col_cnt] + u;
            v_sum = line_v[col_cnt] + v;
            r.chroma_valid = 1'b1;
            r.u_value = u_sum[SAMPLE_W:1];
            r.v_value = v_sum[SAMPLE_W:1];
            if (cur_layout == LAYOUT_NV12) begin
                r.u_addr = 25'(ysize + 2 * c);
                r.v_addr = 25'(ysize + 2 * c + 1);
            end else begin
                r.u_addr = 25'(ysize + c);
                r.v_addr = 25'(ysize + ysize / 4 + c);
            end
        end
        if (last_col) begin
            col_cnt = 0;
            if (last_row) begin
                row_cnt = 0;
                luma_pos = '0;
            end else begin
                row_cnt = row_cnt + 1;
                luma_pos = luma_pos + 24'd2;
            end
        end else begin
            col_cnt = col_cnt + 1;
            luma_pos = luma_pos + 24'd2;
        end
        return r;
    endfunction

    function automatic void plan_write(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] val);
        plan_row_t p;
        p = '{kind: ROW_WRITE, sel: sel, val: val, word: '0, typed: 1'b0, res: '0};
        plan.push_back(p);
    endfunction

    function automatic void plan_pixel(input logic [31:0] word);
        plan_row_t p;
        p = '{kind: ROW_PIXEL, sel: CFG_WIDTH_PAIRS, val: '0, word: word, typed: 1'b0,
              res: '0};
        plan.push_back(p);
    endfunction

    function automatic void plan_typed(input logic [31:0] word, input logic [23:0] la,
                                       input logic [7:0] y0, input logic [7:0] y1,
                                       input logic cv, input logic [24:0] ua,
                                       input logic [24:0] va, input logic [7:0] uv,
                                       input logic [7:0] vv, input logic fl);
        plan_row_t p;
        pixel_result_t r;
        r.luma_addr    = la;
        r.luma_first   = y0;
        r.luma_second  = y1;
        r.chroma_valid = cv;
        r.u_addr       = ua;
        r.v_addr       = va;
        r.u_value      = uv;
        r.v_value      = vv;
        r.frame_last   = fl;
        p = '{kind: ROW_PIXEL, sel: CFG_WIDTH_PAIRS, val: '0, word: word, typed: 1'b1,
              res: r};
        plan.push_back(p);
    endfunction

    // Offers one macropixel, waits for it to be taken and records its result.
    task automatic send_pixel(input logic [31:0] word, input bit typed,
                              input pixel_result_t typed_res);
        int gap;
        pixel_result_t predicted;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = convert_pixel(word);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic let_pipeline_empty();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_setting(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (sel)
            CFG_WIDTH_PAIRS: cur_width  = val;
            CFG_ROW_PAIRS:   cur_rows   = val;
            CFG_BYTE_ORDER:  cur_order  = val[0];
            CFG_PLANAR_OUT:  cur_layout = val[0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat arrived with nothing outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("luma_addr", want.luma_addr, m_tdata[23:0]);
                compare_field("luma_first", want.luma_first, m_tdata[31:24]);
                compare_field("luma_second", want.luma_second, m_tdata[39:32]);
                compare_field("u_addr", want.u_addr, m_tdata[64:40]);
                compare_field("v_addr", want.v_addr, m_tdata[89:65]);
                compare_field("u_value", want.u_value, m_tdata[97:90]);
                compare_field("v_value", want.v_value, m_tdata[105:98]);
                compare_field("chroma_valid", want.chroma_valid, m_tuser);
                compare_field("frame_last", want.frame_last, m_tlast);
            end
        end
    end

    // Ends the run when no beat or register write has moved for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n, target, small_items, r;
        small_items = 0;

        // Reset frame settings, 320 pairs wide: first row, even, so no chroma.
        plan_typed(32'h0000_0000, 24'd0, 8'h00, 8'h00, 1'b0, '0, '0, 8'h00, 8'h00, 1'b0);
        plan_typed(32'hFFFF_FFFF, 24'd2, 8'hFF, 8'hFF, 1'b0, '0, '0, 8'h00, 8'h00, 1'b0);
        plan_typed(32'h1122_3344, 24'd4, 8'h44, 8'h22, 1'b0, '0, '0, 8'h00, 8'h00, 1'b0);
        plan_pixel(32'h3C5A_C3A5);
        // Shrink the frame mid-row: the column counter already sits at the new
        // bound, so the next pixel closes the row.
        plan_write(CFG_WIDTH_PAIRS, 12'd4);
        plan_write(CFG_ROW_PAIRS, 12'd1);
        plan_typed(32'h0123_4567, 24'd8, 8'h67, 8'h23, 1'b0, '0, '0, 8'h00, 8'h00, 1'b0);
        plan_typed(32'hFFFF_FFFF, 24'd10, 8'hFF, 8'hFF, 1'b1, 25'd16, 25'd17, 8'h7F, 8'h7F,
                   1'b0);
        plan_typed(32'hFFFF_FFFF, 24'd12, 8'hFF, 8'hFF, 1'b1, 25'd18, 25'd19, 8'hFF, 8'hFF,
                   1'b0);
        plan_pixel(32'h0000_0000);
        plan_pixel(32'h807F_7F80);
        // Other byte order with separate U and V planes, one whole frame.
        plan_write(CFG_BYTE_ORDER, 12'(ORDER_UYVY));
        plan_write(CFG_PLANAR_OUT, 12'(LAYOUT_I420));
        plan_typed(32'h4433_2211, 24'd0, 8'h22, 8'h44, 1'b0, '0, '0, 8'h00, 8'h00, 1'b0);
        plan_pixel(32'hFFFF_FFFF);
        plan_pixel(32'h0000_0000);
        plan_pixel(32'hA5A5_5A5A);
        plan_typed(32'h00FF_00FF, 24'd8, 8'h00, 8'h00, 1'b1, 25'd16, 25'd20, 8'h88, 8'h99,
                   1'b0);
        plan_pixel(32'h0000_0000);
        plan_pixel(32'hFFFF_FFFF);
        plan_pixel(32'h1234_5678);
        // Zero dimensions are taken as one: a frame of two pixels.
        plan_write(CFG_WIDTH_PAIRS, 12'd0);
        plan_write(CFG_ROW_PAIRS, 12'd0);
        plan_pixel(32'hFFFF_FFFF);
        plan_pixel(32'h0000_0000);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                let_pipeline_empty();
                apply_setting(plan[i].sel, plan[i].val);
            end else begin
                send_pixel(plan[i].word, plan[i].typed, plan[i].res);
            end
        end

        // Oversized dimensions clamp to the largest frame. Part of an even row
        // goes in, then a narrower width closes that row after one more pixel,
        // and one odd row follows under the clamped row count, leaving the
        // counters at the head of an even row.
        let_pipeline_empty();
        apply_setting(CFG_WIDTH_PAIRS, 12'hFFF);
        apply_setting(CFG_ROW_PAIRS, 12'hFFF);
        repeat (24) send_pixel(pick_word(), 1'b0, '0);
        let_pipeline_empty();
        apply_setting(CFG_WIDTH_PAIRS, 12'd25);
        repeat (26) send_pixel(pick_word(), 1'b0, '0);

        // Every phase starts and stops at the head of an even row, so an odd
        // row only ever reads line store entries written just before it.
        while (small_items < RANDOM_PIXELS) begin
            let_pipeline_empty();
            calm = ($urandom_range(3) == 0);
            if ($urandom_range(1) == 1) begin
                r = $urandom_range(99);
                if (r < 5)
                    apply_setting(CFG_WIDTH_PAIRS, 12'd0);
                else if (r < 90)
                    apply_setting(CFG_WIDTH_PAIRS, 12'($urandom_range(8, 1)));
                else
                    apply_setting(CFG_WIDTH_PAIRS, 12'($urandom_range(40, 9)));
            end
            if ($urandom_range(1) == 1) begin
                r = $urandom_range(99);
                if (r < 10)
                    apply_setting(CFG_ROW_PAIRS, 12'd0);
                else if (r < 85)
                    apply_setting(CFG_ROW_PAIRS, 12'($urandom_range(4, 1)));
                else
                    apply_setting(CFG_ROW_PAIRS, 12'($urandom_range(4095, 2048)));
            end
            if ($urandom_range(1) == 1)
                apply_setting(CFG_BYTE_ORDER, 12'($urandom));
            if ($urandom_range(1) == 1)
                apply_setting(CFG_PLANAR_OUT, 12'($urandom));
            target = $urandom_range(60, 10);
            n = 0;
            while (n < target || col_cnt != 0 || row_cnt % 2 != 0) begin
                send_pixel(pick_word(), 1'b0, '0);
                n++;
            end
            small_items += n;
        end

        let_pipeline_empty();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- packed422_to_420_chroma_average_top.f -----
sv/p422c_pkg.sv
sv/p422c_line_store.sv
sv/packed422_to_420_chroma_average_top.sv
tb/sv/tb_top.sv
